// ===== src/pwbs_pkg.sv =====
package pwbs_pkg;

	localparam int PIX_W    = 8;
	localparam int IDX_W    = 16;
	localparam int MEAN_W   = 24;
	localparam int M2_W     = 40;
	localparam int N_W      = 16;
	localparam int FRAME_W  = 17;
	localparam int FLOOR_W  = 16;
	localparam int SCORE_W  = 23;
	localparam int STATUS_W = 2;
	localparam int CFG_A_W  = 2;

	localparam int MAX_PIXELS = 65536;
	localparam logic [FRAME_W-1:0] MAX_PIX_V = FRAME_W'(MAX_PIXELS);
	localparam logic [N_W-1:0] MAX_FRAMES = 16'd65535;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 23'd6528000;
	localparam logic [FLOOR_W-1:0] FLOOR_MIN = 16'd3;

	// both dividers: 48-bit dividend, 24-bit divisor, 4 quotient bits per stage
	localparam int NUM_W      = 48;
	localparam int DEN_W      = 24;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = NUM_W / DIV_STEPS;

	// square root: 48-bit radicand, 24-bit root, 4 root bits per stage
	localparam int ROOT_W    = NUM_W / 2;
	localparam int SQREM_W   = ROOT_W + 2;
	localparam int SQ_STEPS  = 4;
	localparam int SQ_STAGES = ROOT_W / SQ_STEPS;

	typedef enum logic [STATUS_W-1:0] {
		ST_TEACH  = 2'd0,
		ST_SCORE  = 2'd1,
		ST_NOBASE = 2'd2
	} status_t;

	typedef enum logic [CFG_A_W-1:0] {
		REG_MODE  = 2'd0,
		REG_FLOOR = 2'd1,
		REG_FRAME = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] nq;
		logic [DEN_W-1:0] dvs;
	} div_t;

	typedef struct packed {
		logic [SQREM_W-1:0] rem;
		logic [ROOT_W-1:0]  root;
		logic [NUM_W-1:0]   rad;
	} sq_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [PIX_W-1:0]  x;
		logic              last;
		logic              teach;
		logic              first;
		logic              in_frame;
		status_t           status;
		logic [N_W-1:0]    n;
		logic [MEAN_W-1:0] mean;
		logic [M2_W-1:0]   m2;
		logic              neg;
		logic [MEAN_W-1:0] mag;
		logic [MEAN_W-1:0] mag2;
		logic [MEAN_W:0]   prod;
	} pay_t;

endpackage

// ===== src/pwbs_store.sv =====
module pwbs_store (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [pwbs_pkg::IDX_W-1:0]     rd_addr,
	output logic [pwbs_pkg::MEAN_W-1:0]    rd_mean,
	output logic [pwbs_pkg::M2_W-1:0]      rd_m2,
	input  logic                           wr_en,
	input  logic [pwbs_pkg::IDX_W-1:0]     wr_addr,
	input  logic [pwbs_pkg::MEAN_W-1:0]    wr_mean,
	input  logic [pwbs_pkg::M2_W-1:0]      wr_m2
);

	logic [pwbs_pkg::MEAN_W-1:0] mean_mem [0:pwbs_pkg::MAX_PIXELS-1];
	logic [pwbs_pkg::M2_W-1:0]   m2_mem   [0:pwbs_pkg::MAX_PIXELS-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mean_mem[wr_addr] <= wr_mean;
			m2_mem[wr_addr]   <= wr_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_mean <= mean_mem[rd_addr];
			rd_m2   <= m2_mem[rd_addr];
		end
	end

endmodule

// ===== src/pwbs_div_stage.sv =====
module pwbs_div_stage (
	input  logic            clk,
	input  logic            en,
	input  pwbs_pkg::div_t  d_in,
	output pwbs_pkg::div_t  d_out
);

	pwbs_pkg::div_t nxt;

	// restoring division, one quotient bit per step shifted into nq
	always_comb begin
		logic [pwbs_pkg::DEN_W:0]   t;
		logic [pwbs_pkg::DEN_W-1:0] r;
		logic [pwbs_pkg::NUM_W-1:0] q;
		r = d_in.rem;
		q = d_in.nq;
		for (int i = 0; i < pwbs_pkg::DIV_STEPS; i++) begin
			t = {r, q[pwbs_pkg::NUM_W-1]};
			q = {q[pwbs_pkg::NUM_W-2:0], 1'b0};
			if (t >= {1'b0, d_in.dvs}) begin
				t    = t - {1'b0, d_in.dvs};
				q[0] = 1'b1;
			end
			r = t[pwbs_pkg::DEN_W-1:0];
		end
		nxt.rem = r;
		nxt.nq  = q;
		nxt.dvs = d_in.dvs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

// ===== src/pwbs_sqrt_stage.sv =====
module pwbs_sqrt_stage (
	input  logic           clk,
	input  logic           en,
	input  pwbs_pkg::sq_t  s_in,
	output pwbs_pkg::sq_t  s_out
);

	pwbs_pkg::sq_t nxt;

	// digit-by-digit integer root, two radicand bits per root bit
	always_comb begin
		logic [pwbs_pkg::SQREM_W+1:0] t;
		logic [pwbs_pkg::SQREM_W+1:0] trial;
		logic [pwbs_pkg::SQREM_W-1:0] r;
		logic [pwbs_pkg::ROOT_W-1:0]  root;
		logic [pwbs_pkg::NUM_W-1:0]   rad;
		r    = s_in.rem;
		root = s_in.root;
		rad  = s_in.rad;
		for (int i = 0; i < pwbs_pkg::SQ_STEPS; i++) begin
			t     = {r, rad[pwbs_pkg::NUM_W-1 -: 2]};
			rad   = {rad[pwbs_pkg::NUM_W-3:0], 2'b00};
			trial = {2'b00, root, 2'b01};
			if (t >= trial) begin
				t    = t - trial;
				root = {root[pwbs_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				root = {root[pwbs_pkg::ROOT_W-2:0], 1'b0};
			end
			r = t[pwbs_pkg::SQREM_W-1:0];
		end
		nxt.rem  = r;
		nxt.root = root;
		nxt.rad  = rad;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_out <= nxt;
		end
	end

endmodule

// ===== src/pixel_welford_baseline_scorer_core.sv =====
// channel  | dir | signals                        | contents
// s_*      | in  | s_tvalid s_tready s_tdata s_tlast | pixel, pixel_index; tlast last_pixel
// m_*      | out | m_tvalid m_tready m_tdata m_tlast | score, status; tlast frame_end
// cfg_*    | in  | cfg_we cfg_addr cfg_data          | mode, sigma_floor, frame_pixels
//
// one item per cycle unless held off or stalled; from accept to result an item passes the
// store read, the two 12-stage dividers and the 6-stage square root
// teach items update the per-pixel store at the write stage; an item whose
// pixel_index matches a teach item not yet written to the store is held off
// a result waiting on m_tready freezes the whole pipeline and s_tready drops
// reset clears the control state and the frame count; the stores need no clearing
module pixel_welford_baseline_scorer_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [23:0]                      s_tdata,  // pixel[7:0], pixel_index[23:8]
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata,  // score[22:0], status[24:23], zeros
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [pwbs_pkg::CFG_A_W-1:0]     cfg_addr,
	input  logic [pwbs_pkg::FRAME_W-1:0]     cfg_data
);

	localparam int STG_DIV1_IN  = 2;
	localparam int STG_DIV1_OUT = STG_DIV1_IN + pwbs_pkg::DIV_STAGES;
	localparam int STG_SQ_IN    = STG_DIV1_OUT + 1;
	localparam int STG_TSTEP    = STG_DIV1_OUT + 1;
	localparam int STG_TPROD    = STG_TSTEP + 1;
	localparam int STG_TWRITE   = STG_TPROD + 1;
	localparam int STG_SQ_OUT   = STG_SQ_IN + pwbs_pkg::SQ_STAGES;
	localparam int STG_DIV2_IN  = STG_SQ_OUT + 1;
	localparam int STG_DIV2_OUT = STG_DIV2_IN + pwbs_pkg::DIV_STAGES;
	localparam int STG_OUT      = STG_DIV2_OUT + 1;

	// configuration and frame count
	logic                             mode_q;
	logic [pwbs_pkg::FLOOR_W-1:0]     floor_q;
	logic [pwbs_pkg::FRAME_W-1:0]     frame_q;
	logic [pwbs_pkg::N_W-1:0]         frames_q;

	logic                             adv;
	logic                             in_acc;
	logic                             haz;
	logic [pwbs_pkg::IDX_W-1:0]       in_idx;
	logic [pwbs_pkg::PIX_W-1:0]       in_x;
	logic [pwbs_pkg::FRAME_W-1:0]     size;
	logic                             in_inside;
	pwbs_pkg::pay_t                   pay_in;

	logic [STG_OUT:1]                 val_q;
	pwbs_pkg::pay_t                   pay_q [1:STG_OUT];

	logic [pwbs_pkg::MEAN_W-1:0]      rd_mean;
	logic [pwbs_pkg::M2_W-1:0]        rd_m2;

	pwbs_pkg::div_t                   d1_q [0:pwbs_pkg::DIV_STAGES];
	pwbs_pkg::div_t                   d2_q [0:pwbs_pkg::DIV_STAGES];
	pwbs_pkg::sq_t                    sq_q [0:pwbs_pkg::SQ_STAGES];

	pwbs_pkg::pay_t                   prep_pay;
	pwbs_pkg::div_t                   d1_in;
	pwbs_pkg::pay_t                   step_pay;
	pwbs_pkg::pay_t                   prod_pay;
	pwbs_pkg::pay_t                   wr_pay;
	pwbs_pkg::div_t                   d2_in;
	logic [pwbs_pkg::SCORE_W-1:0]     score_nxt;
	logic [pwbs_pkg::SCORE_W-1:0]     score_s35;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			floor_q <= pwbs_pkg::FLOOR_MIN;
			frame_q <= pwbs_pkg::MAX_PIX_V;
		end else if (cfg_we) begin
			case (cfg_addr)
				pwbs_pkg::REG_MODE:  mode_q  <= cfg_data[0];
				pwbs_pkg::REG_FLOOR: floor_q <= cfg_data[pwbs_pkg::FLOOR_W-1:0];
				pwbs_pkg::REG_FRAME: frame_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
		end else if (in_acc && !mode_q && s_tlast && frames_q < pwbs_pkg::MAX_FRAMES) begin
			frames_q <= frames_q + 1'b1;
		end
	end

	// input side
	assign adv    = !val_q[STG_OUT] || m_tready;
	assign in_x   = s_tdata[pwbs_pkg::PIX_W-1:0];
	assign in_idx = s_tdata[pwbs_pkg::PIX_W +: pwbs_pkg::IDX_W];
	assign size   = (frame_q < pwbs_pkg::MAX_PIX_V) ? frame_q : pwbs_pkg::MAX_PIX_V;
	assign in_inside = {1'b0, in_idx} < size;

	// hold off a read of an entry that an in-flight teach item still has to write
	always_comb begin
		haz = 1'b0;
		for (int k = 1; k <= STG_TWRITE; k++) begin
			if (val_q[k] && pay_q[k].teach && pay_q[k].in_frame && pay_q[k].idx == in_idx) begin
				haz = 1'b1;
			end
		end
	end

	assign s_tready = adv && !haz;
	assign in_acc   = s_tvalid && s_tready;

	always_comb begin
		pay_in          = '0;
		pay_in.idx      = in_idx;
		pay_in.x        = in_x;
		pay_in.last     = s_tlast;
		pay_in.teach    = !mode_q;
		pay_in.first    = frames_q == '0;
		pay_in.in_frame = in_inside;
		pay_in.n        = frames_q;
		if (!mode_q) begin
			pay_in.status = pwbs_pkg::ST_TEACH;
		end else if (frames_q == '0 || !in_inside) begin
			pay_in.status = pwbs_pkg::ST_NOBASE;
		end else begin
			pay_in.status = pwbs_pkg::ST_SCORE;
		end
	end

	pwbs_store u_store (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (in_idx),
		.rd_mean (rd_mean),
		.rd_m2   (rd_m2),
		.wr_en   (val_q[STG_TWRITE] && pay_q[STG_TWRITE].teach && pay_q[STG_TWRITE].in_frame),
		.wr_addr (pay_q[STG_TWRITE].idx),
		.wr_mean (pay_q[STG_TWRITE].mean),
		.wr_m2   (pay_q[STG_TWRITE].m2)
	);

	// stage 1 -> 2: deviation and divider operands
	always_comb begin
		logic [pwbs_pkg::MEAN_W-1:0] xq;
		logic [pwbs_pkg::N_W:0]      dv;
		prep_pay      = pay_q[1];
		xq            = {pay_q[1].x, 16'd0};
		prep_pay.mean = rd_mean;
		prep_pay.m2   = rd_m2;
		prep_pay.neg  = xq < rd_mean;
		prep_pay.mag  = (xq < rd_mean) ? rd_mean - xq : xq - rd_mean;
		dv            = {1'b0, pay_q[1].n} + 1'b1;
		d1_in.rem     = '0;
		if (pay_q[1].teach) begin
			d1_in.nq  = pwbs_pkg::NUM_W'(prep_pay.mag) + pwbs_pkg::NUM_W'(dv >> 1);
			d1_in.dvs = pwbs_pkg::DEN_W'(dv);
		end else begin
			d1_in.nq  = {rd_m2, 8'd0};
			d1_in.dvs = pwbs_pkg::DEN_W'(pay_q[1].n);
		end
	end

	// teach: mean step and remaining deviation
	always_comb begin
		logic [pwbs_pkg::MEAN_W-1:0] step;
		step          = d1_q[pwbs_pkg::DIV_STAGES].nq[pwbs_pkg::MEAN_W-1:0];
		step_pay      = pay_q[STG_TSTEP-1];
		step_pay.mean = pay_q[STG_TSTEP-1].neg ? pay_q[STG_TSTEP-1].mean - step
		                                       : pay_q[STG_TSTEP-1].mean + step;
		step_pay.mag2 = pay_q[STG_TSTEP-1].mag - step;
	end

	// teach: product of the two deviations, rounded to Q.8
	always_comb begin
		logic [2*pwbs_pkg::MEAN_W-1:0] mul;
		logic [2*pwbs_pkg::MEAN_W:0]   sum;
		mul           = pay_q[STG_TPROD-1].mag * pay_q[STG_TPROD-1].mag2;
		sum           = {1'b0, mul} + (49'd1 << 23);
		prod_pay      = pay_q[STG_TPROD-1];
		prod_pay.prod = sum[2*pwbs_pkg::MEAN_W -: (pwbs_pkg::MEAN_W + 1)];
	end

	// teach: saturating accumulate, or seed on the first frame
	always_comb begin
		logic [pwbs_pkg::M2_W:0] s;
		s      = {1'b0, pay_q[STG_TWRITE-1].m2} + (pwbs_pkg::M2_W + 1)'(pay_q[STG_TWRITE-1].prod);
		wr_pay = pay_q[STG_TWRITE-1];
		if (pay_q[STG_TWRITE-1].first) begin
			wr_pay.mean = {pay_q[STG_TWRITE-1].x, 16'd0};
			wr_pay.m2   = '0;
		end else begin
			wr_pay.m2 = s[pwbs_pkg::M2_W] ? '1 : s[pwbs_pkg::M2_W-1:0];
		end
	end

	// score: denominator against the floor and rounded dividend
	always_comb begin
		logic [pwbs_pkg::FLOOR_W-1:0] fl;
		logic [pwbs_pkg::DEN_W-1:0]   sigma;
		logic [pwbs_pkg::DEN_W-1:0]   den;
		fl        = (floor_q < pwbs_pkg::FLOOR_MIN) ? pwbs_pkg::FLOOR_MIN : floor_q;
		sigma     = sq_q[pwbs_pkg::SQ_STAGES].root;
		den       = (sigma > pwbs_pkg::DEN_W'(fl)) ? sigma : pwbs_pkg::DEN_W'(fl);
		d2_in.rem = '0;
		d2_in.nq  = pwbs_pkg::NUM_W'(pay_q[STG_DIV2_IN-1].mag) + pwbs_pkg::NUM_W'(den >> 1);
		d2_in.dvs = den;
	end

	always_comb begin
		logic [pwbs_pkg::NUM_W-1:0] q;
		q = d2_q[pwbs_pkg::DIV_STAGES].nq;
		if (pay_q[STG_OUT-1].status != pwbs_pkg::ST_SCORE) begin
			score_nxt = '0;
		end else if (q > pwbs_pkg::NUM_W'(pwbs_pkg::SCORE_MAX)) begin
			score_nxt = pwbs_pkg::SCORE_MAX;
		end else begin
			score_nxt = q[pwbs_pkg::SCORE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (adv) begin
			val_q <= {val_q[STG_OUT-1:1], in_acc};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q[1] <= pay_in;
			for (int k = 2; k <= STG_OUT; k++) begin
				pay_q[k] <= pay_q[k-1];
			end
			pay_q[STG_DIV1_IN] <= prep_pay;
			pay_q[STG_TSTEP]   <= step_pay;
			pay_q[STG_TPROD]   <= prod_pay;
			pay_q[STG_TWRITE]  <= wr_pay;
			d1_q[0]   <= d1_in;
			sq_q[0]   <= '{rem: '0, root: '0, rad: d1_q[pwbs_pkg::DIV_STAGES].nq};
			d2_q[0]   <= d2_in;
			score_s35 <= score_nxt;
		end
	end

	for (genvar g = 0; g < pwbs_pkg::DIV_STAGES; g++) begin : g_div1
		pwbs_div_stage u_div (
			.clk   (clk),
			.en    (adv),
			.d_in  (d1_q[g]),
			.d_out (d1_q[g+1])
		);
	end

	for (genvar g = 0; g < pwbs_pkg::SQ_STAGES; g++) begin : g_sqrt
		pwbs_sqrt_stage u_sqrt (
			.clk   (clk),
			.en    (adv),
			.s_in  (sq_q[g]),
			.s_out (sq_q[g+1])
		);
	end

	for (genvar g = 0; g < pwbs_pkg::DIV_STAGES; g++) begin : g_div2
		pwbs_div_stage u_div (
			.clk   (clk),
			.en    (adv),
			.d_in  (d2_q[g]),
			.d_out (d2_q[g+1])
		);
	end

	assign m_tvalid = val_q[STG_OUT];
	assign m_tdata  = {7'd0, pay_q[STG_OUT].status, score_s35};
	assign m_tlast  = pay_q[STG_OUT].last;

endmodule
